@@ sv/qhmd_pkg.sv @@
// shared types and constants for the query-hit marker detector
`default_nettype none

package qhmd_pkg;

	localparam logic [15:0] MARKER_RESET    = 16'd409;
	localparam logic [7:0]  HEADER_BYTES    = 8'd11;
	localparam logic [7:0]  HIT_FIXED_BYTES = 8'd8;
	localparam logic [7:0]  VENDOR_BYTES    = 8'd4;

	typedef enum logic [3:0] {
		PH_HEADER    = 4'd0,
		PH_HIT_FIXED = 4'd1,
		PH_NAME      = 4'd2,
		PH_INFO      = 4'd3,
		PH_VENDOR    = 4'd4,
		PH_OPEN_LEN  = 4'd5,
		PH_OPEN_DATA = 4'd6,
		PH_PRIV_LO   = 4'd7,
		PH_PRIV_HI   = 4'd8,
		PH_DONE      = 4'd9
	} phase_t;

	// one payload byte held in the input stage
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_stage_t;

	typedef struct packed {
		logic is_marked;
		logic private_seen;
	} verdict_t;

endpackage

`default_nettype wire

@@ sv/qhmd_stream_if.sv @@
// valid/ready channel interfaces for payload bytes and verdicts
`default_nettype none

interface qhmd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface qhmd_verdict_if;
	logic valid;
	logic ready;
	logic is_marked;
	logic private_seen;

	modport source (output valid, output is_marked, output private_seen, input ready);
	modport sink (input valid, input is_marked, input private_seen, output ready);
endinterface

`default_nettype wire

@@ sv/qhmd_in_stage.sv @@
// input register stage for payload bytes
`default_nettype none

module qhmd_in_stage
	import qhmd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	qhmd_byte_if.sink   byte_in,
	input  wire logic   advance,
	output byte_stage_t stage_s1
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       accept;

	assign byte_in.ready = !valid_s1 || advance;
	assign accept        = byte_in.valid && byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last_byte;
		end
	end

	assign stage_s1 = '{valid: valid_s1, data_byte: data_s1, last_byte: last_s1};

endmodule

`default_nettype wire

@@ sv/qhmd_parser.sv @@
// payload layout walker and private word compare
`default_nettype none

module qhmd_parser
	import qhmd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire byte_stage_t stage_s1,
	input  wire logic        advance,
	input  wire logic [15:0] marker_value,
	output verdict_t         verdict
);

	phase_t     phase_q, phase_d;
	logic [7:0] count_q, count_d;
	logic [7:0] hits_q, hits_d;
	logic [7:0] low_q, low_d;
	logic [1:0] vbits_q, vbits_d;
	logic [7:0] b;
	logic [7:0] dec;
	logic [7:0] inc;
	logic [7:0] hits_dec;

	assign b        = stage_s1.data_byte;
	assign dec      = count_q - 8'd1;
	assign inc      = count_q + 8'd1;
	assign hits_dec = hits_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		hits_d  = hits_q;
		low_d   = low_q;
		vbits_d = vbits_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (count_q == 8'd0) begin
					hits_d = b;
				end
				count_d = inc;
				if (inc >= HEADER_BYTES) begin
					// hit count comes from this byte only when the header is one byte
					if (((count_q == 8'd0) ? b : hits_q) != 8'd0) begin
						phase_d = PH_HIT_FIXED;
						count_d = HIT_FIXED_BYTES;
					end else begin
						phase_d = PH_VENDOR;
						count_d = VENDOR_BYTES;
					end
				end
			end
			PH_HIT_FIXED: begin
				count_d = dec;
				if (dec == 8'd0) begin
					phase_d = PH_NAME;
				end
			end
			PH_NAME: begin
				if (b == 8'd0) begin
					phase_d = PH_INFO;
				end
			end
			PH_INFO: begin
				if (b == 8'd0) begin
					hits_d = hits_dec;
					if (hits_dec != 8'd0) begin
						phase_d = PH_HIT_FIXED;
						count_d = HIT_FIXED_BYTES;
					end else begin
						phase_d = PH_VENDOR;
						count_d = VENDOR_BYTES;
					end
				end
			end
			PH_VENDOR: begin
				count_d = dec;
				if (dec == 8'd0) begin
					phase_d = PH_OPEN_LEN;
				end
			end
			PH_OPEN_LEN: begin
				if (b == 8'd0) begin
					phase_d = PH_PRIV_LO;
				end else begin
					count_d = b;
					phase_d = PH_OPEN_DATA;
				end
			end
			PH_OPEN_DATA: begin
				count_d = dec;
				if (dec == 8'd0) begin
					phase_d = PH_PRIV_LO;
				end
			end
			PH_PRIV_LO: begin
				low_d   = b;
				phase_d = PH_PRIV_HI;
			end
			PH_PRIV_HI: begin
				vbits_d = {1'b1, ({b, low_q} == marker_value)};
				phase_d = PH_DONE;
			end
			default: begin
				// done phase and unused codes ignore their bytes
			end
		endcase
	end

	assign verdict = '{is_marked: vbits_d[0], private_seen: vbits_d[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= 8'd0;
			hits_q  <= 8'd0;
			low_q   <= 8'd0;
			vbits_q <= 2'd0;
		end else if (advance) begin
			if (stage_s1.last_byte) begin
				phase_q <= PH_HEADER;
				count_q <= 8'd0;
				hits_q  <= 8'd0;
				low_q   <= 8'd0;
				vbits_q <= 2'd0;
			end else begin
				phase_q <= phase_d;
				count_q <= count_d;
				hits_q  <= hits_d;
				low_q   <= low_d;
				vbits_q <= vbits_d;
			end
		end
	end

	a_fresh_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && stage_s1.last_byte |=> phase_q == PH_HEADER && count_q == 8'd0
			&& vbits_q == 2'd0)
		else $error("parse state not cleared after last byte");

	a_marked_needs_seen: assert property (@(posedge clk) disable iff (!arst_n)
		vbits_q[0] |-> vbits_q[1])
		else $error("marked verdict without private word");

	a_verdict_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		vbits_q[1] |-> phase_q == PH_DONE)
		else $error("private word seen outside done phase");

	a_header_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> count_q < HEADER_BYTES)
		else $error("header index out of range");

endmodule

`default_nettype wire

@@ sv/qhmd_out_stage.sv @@
// result register for verdict items
`default_nettype none

module qhmd_out_stage
	import qhmd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire verdict_t verdict,
	output logic          slot_free,
	qhmd_verdict_if.source verdict_out
);

	logic     valid_q;
	verdict_t data_q;

	assign slot_free = !valid_q || verdict_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= verdict;
		end
	end

	assign verdict_out.valid        = valid_q;
	assign verdict_out.is_marked    = data_q.is_marked;
	assign verdict_out.private_seen = data_q.private_seen;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> slot_free)
		else $error("verdict overwritten before taken");

endmodule

`default_nettype wire

@@ sv/query_hit_marker_detector.sv @@
// top level of the query-hit marker detector
// throughput: one payload byte per cycle, sustained, with no gaps between messages, while the result slot is free
// a verdict passes the input stage and then the result register after its last byte is accepted
// a full result slot holds only last bytes; bytes before one keep flowing into the parser
// reset: asynchronous, clears parse state and both stages, marker returns to 409
`default_nettype none

module query_hit_marker_detector
	import qhmd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	qhmd_byte_if.sink        byte_in,
	qhmd_verdict_if.source   verdict_out
);

	// marker register; the user must write it only while the block is idle, the block itself does not enforce it
	logic [15:0] marker_q;

	byte_stage_t stage_s1;
	verdict_t    verdict;
	logic        slot_free;
	logic        advance;
	logic        push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_we) begin
			marker_q <= cfg_data;
		end
	end

	// a byte leaves the input stage unless it ends a message and the result slot is full
	assign advance = stage_s1.valid && (!stage_s1.last_byte || slot_free);
	// only the last byte of a message produces a verdict item
	assign push    = advance && stage_s1.last_byte;

	// input register stage
	qhmd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.advance  (advance),
		.stage_s1 (stage_s1)
	);

	// layout walker: phase, field countdown, hit count, private low byte
	qhmd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage_s1     (stage_s1),
		.advance      (advance),
		.marker_value (marker_q),
		.verdict      (verdict)
	);

	// result register toward the verdict channel
	qhmd_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.verdict     (verdict),
		.slot_free   (slot_free),
		.verdict_out (verdict_out)
	);

endmodule

`default_nettype wire

@@ verif/query_hit_marker_detector_tb.sv @@
// self-checking testbench for the query-hit marker detector: directed and random payloads
`default_nettype none

module query_hit_marker_detector_tb
	import qhmd_pkg::*;
;

	// generous bound, well above the slowest legal run
	localparam int CYCLE_LIMIT = 300000;
	// spare cycles for a verdict to pass the input stage and result register after its last byte
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_BYTES = 150;
	localparam int PHASE_MESSAGES = 4;

	// tracks the parse of the byte stream and holds the verdicts still due
	class hit_verdict_tracker;
		phase_t      phase;
		logic [7:0]  countdown;
		logic [7:0]  hits_left;
		logic [7:0]  priv_lo;
		logic [1:0]  verdict_bits;
		logic [15:0] marker;
		verdict_t    due_verdicts[$];
		int          errors;
		int          byte_count;
		int          message_count;
		int          marked_count;

		function new();
			marker = MARKER_RESET;
			clear_parse();
		endfunction

		function void clear_parse();
			phase = PH_HEADER;
			countdown = '0;
			hits_left = '0;
			priv_lo = '0;
			verdict_bits = '0;
		endfunction

		function void set_marker(logic [15:0] value);
			marker = value;
		endfunction

		function void enter_hit_or_vendor();
			if (hits_left != 8'd0) begin
				phase = PH_HIT_FIXED;
				countdown = HIT_FIXED_BYTES;
			end else begin
				phase = PH_VENDOR;
				countdown = VENDOR_BYTES;
			end
		endfunction

		// one accepted payload item; a last byte leaves one verdict due
		function void note_byte(logic [7:0] b, logic last);
			verdict_t v;
			byte_count++;
			case (phase)
				PH_HEADER: begin
					if (countdown == 8'd0)
						hits_left = b;
					countdown = countdown + 8'd1;
					if (countdown >= HEADER_BYTES)
						enter_hit_or_vendor();
				end
				PH_HIT_FIXED: begin
					countdown = countdown - 8'd1;
					if (countdown == 8'd0)
						phase = PH_NAME;
				end
				PH_NAME: begin
					if (b == 8'd0)
						phase = PH_INFO;
				end
				PH_INFO: begin
					if (b == 8'd0) begin
						hits_left = hits_left - 8'd1;
						enter_hit_or_vendor();
					end
				end
				PH_VENDOR: begin
					countdown = countdown - 8'd1;
					if (countdown == 8'd0)
						phase = PH_OPEN_LEN;
				end
				PH_OPEN_LEN: begin
					if (b == 8'd0) begin
						phase = PH_PRIV_LO;
					end else begin
						countdown = b;
						phase = PH_OPEN_DATA;
					end
				end
				PH_OPEN_DATA: begin
					countdown = countdown - 8'd1;
					if (countdown == 8'd0)
						phase = PH_PRIV_LO;
				end
				PH_PRIV_LO: begin
					priv_lo = b;
					phase = PH_PRIV_HI;
				end
				PH_PRIV_HI: begin
					verdict_bits = {1'b1, ({b, priv_lo} == marker)};
					phase = PH_DONE;
				end
				default: ;
			endcase
			if (last) begin
				v.is_marked = verdict_bits[0];
				v.private_seen = verdict_bits[1];
				due_verdicts.push_back(v);
				message_count++;
				clear_parse();
			end
		endfunction

		function void check_verdict(logic is_marked, logic private_seen);
			verdict_t want;
			if (due_verdicts.size() == 0) begin
				$error("verdict with none due: is_marked=%0b private_seen=%0b",
					is_marked, private_seen);
				errors++;
			end else begin
				want = due_verdicts.pop_front();
				if (is_marked !== want.is_marked) begin
					$error("is_marked: expected %0b, got %0b", want.is_marked, is_marked);
					errors++;
				end
				if (private_seen !== want.private_seen) begin
					$error("private_seen: expected %0b, got %0b",
						want.private_seen, private_seen);
					errors++;
				end
				if (want.is_marked)
					marked_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;

	qhmd_byte_if    byte_if ();
	qhmd_verdict_if verdict_if ();

	query_hit_marker_detector u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.byte_in     (byte_if),
		.verdict_out (verdict_if)
	);

	hit_verdict_tracker board = new();

	// idle chances in percent for sender and receiver, changed per phase
	int src_idle_pct;
	int snk_idle_pct;
	int marker_writes;
	logic [7:0] msg_bytes[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** query_hit_marker_detector: FAILED **");
		$finish;
	end

	// receiver: ready changes on the falling edge, stalls at random
	initial begin
		verdict_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			verdict_if.ready = ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// both handshakes are sampled at the rising edge
	always @(posedge clk) begin
		if (byte_if.valid && byte_if.ready)
			board.note_byte(byte_if.data_byte, byte_if.last_byte);
		if (verdict_if.valid && verdict_if.ready)
			board.check_verdict(verdict_if.is_marked, verdict_if.private_seen);
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_if.valid = 1'b0;
			@(negedge clk);
		end
		byte_if.valid = 1'b1;
		byte_if.data_byte = b;
		byte_if.last_byte = last;
		do @(posedge clk); while (!byte_if.ready);
		@(negedge clk);
	endtask

	task automatic send_message();
		foreach (msg_bytes[i])
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
	endtask

	// marker changes only once the block has drained every verdict
	task automatic write_marker(input logic [15:0] value);
		byte_if.valid = 1'b0;
		while (board.due_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = value;
		board.set_marker(value);
		marker_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// zero-terminated string with a short random body
	function automatic void push_string();
		int n;
		n = $urandom_range(0, 4);
		repeat (n) msg_bytes.push_back(8'($urandom_range(1, 255)));
		msg_bytes.push_back(8'd0);
	endfunction

	// mostly well-formed messages, plus cut-off ones and plain noise
	function automatic void build_random_message();
		int kind;
		int hits;
		int open_len;
		int pick;
		logic [15:0] word;
		msg_bytes.delete();
		kind = $urandom_range(99);
		if (kind >= 85) begin
			repeat ($urandom_range(1, 40)) msg_bytes.push_back(8'($urandom));
			return;
		end
		// header: hit count first, then ten random bytes
		hits = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3);
		msg_bytes.push_back(8'(hits));
		repeat (10) msg_bytes.push_back(8'($urandom));
		repeat (hits) begin
			repeat (8) msg_bytes.push_back(8'($urandom));
			push_string();
			push_string();
		end
		repeat (4) msg_bytes.push_back(8'($urandom));
		// open data: often empty, seldom near the maximum length
		pick = $urandom_range(99);
		if (pick < 30)
			open_len = 0;
		else if (pick < 96)
			open_len = $urandom_range(1, 8);
		else if (pick < 99)
			open_len = $urandom_range(200, 254);
		else
			open_len = 255;
		msg_bytes.push_back(8'(open_len));
		repeat (open_len) msg_bytes.push_back(8'($urandom));
		// private word: a hit, a one-bit near miss or anything
		pick = $urandom_range(99);
		if (pick < 45)
			word = board.marker;
		else if (pick < 65)
			word = board.marker ^ (16'd1 << $urandom_range(15));
		else
			word = 16'($urandom);
		msg_bytes.push_back(word[7:0]);
		msg_bytes.push_back(word[15:8]);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
		// cut-off message: ends somewhere before its full length
		if (kind >= 70)
			msg_bytes = msg_bytes[0:$urandom_range(0, msg_bytes.size() - 2)];
	endfunction

	initial begin
		logic [15:0] markers[RANDOM_PHASES];
		int start_bytes;
		int start_msgs;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		byte_if.valid = 1'b0;
		byte_if.data_byte = '0;
		byte_if.last_byte = 1'b0;
		src_idle_pct = 15;
		snk_idle_pct = 63;
		marker_writes = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, under the reset marker
		// a message of one byte ends before anything is parsed
		msg_bytes = '{8'hFF};
		send_message();
		// no hits, no open data, private word equals 409, one trailing byte
		msg_bytes = '{8'h00};
		repeat (10) msg_bytes.push_back(8'hFF);
		repeat (4) msg_bytes.push_back(8'h00);
		msg_bytes.push_back(8'h00);
		msg_bytes.push_back(MARKER_RESET[7:0]);
		msg_bytes.push_back(MARKER_RESET[15:8]);
		msg_bytes.push_back(8'hFF);
		send_message();
		// one hit whose name string never terminates
		msg_bytes = '{8'h01};
		repeat (10) msg_bytes.push_back(8'h5A);
		repeat (8) msg_bytes.push_back(8'hA5);
		msg_bytes.push_back(8'h41);
		send_message();

		// random part: extremes of the marker first, then other values
		markers[0] = 16'h0000;
		markers[1] = 16'hFFFF;
		markers[2] = 16'($urandom);
		markers[3] = 16'($urandom);
		markers[4] = 16'h0001;
		markers[5] = MARKER_RESET;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			// two phases per idling pattern, the last pair without any idling
			case (ph / 2)
				0: begin
					src_idle_pct = 15;
					snk_idle_pct = 63;
				end
				1: begin
					src_idle_pct = 63;
					snk_idle_pct = 15;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			write_marker(markers[ph]);
			start_bytes = board.byte_count;
			start_msgs = board.message_count;
			while (board.byte_count - start_bytes < PHASE_BYTES ||
					board.message_count - start_msgs < PHASE_MESSAGES) begin
				build_random_message();
				send_message();
			end
		end

		// drain: every verdict back, then a short quiet stretch
		byte_if.valid = 1'b0;
		while (board.due_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.due_verdicts.size() != 0) begin
			$error("%0d verdicts never arrived", board.due_verdicts.size());
			board.errors++;
		end

		$display("run: %0d payload bytes in %0d messages, %0d flagged verdicts",
			board.byte_count, board.message_count, board.marked_count);
		$display("run: %0d marker settings across three idling patterns, %0d errors",
			marker_writes, board.errors);
		if (board.errors == 0)
			$display("** query_hit_marker_detector: PASSED **");
		else
			$display("** query_hit_marker_detector: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
sv/qhmd_pkg.sv
sv/qhmd_stream_if.sv
sv/qhmd_in_stage.sv
sv/qhmd_parser.sv
sv/qhmd_out_stage.sv
sv/query_hit_marker_detector.sv
verif/query_hit_marker_detector_tb.sv
